// ===== hdl/fleet_stats_aggregator_unit_macros.svh =====
`ifndef FLEET_STATS_AGGREGATOR_UNIT_MACROS_SVH
`define FLEET_STATS_AGGREGATOR_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define FSA_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FSA_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fsa_pkg.sv =====
`default_nettype none

package fsa_pkg;

    localparam int ENT_W      = 32;
    localparam int CTR_W      = 48;
    localparam int SUM40_W    = 40;
    localparam int SUM56_W    = 56;
    localparam int CNT_OUT_W  = 9;
    localparam int MODE_W     = 2;
    localparam int K_W        = 8;
    localparam int ALU_W      = 56;
    localparam int DIVIDEND_W = SUM40_W + 1;
    localparam int DCNT_W     = $clog2(DIVIDEND_W + 1);

    typedef enum logic [1:0] {
        SAT_NONE,
        SAT_40,
        SAT_56
    } sat_t;

    typedef struct packed {
        logic sub;
        sat_t sat;
    } alu_ctrl_t;

    typedef struct packed {
        logic               first;
        logic               present;
        logic               last;
        logic [ENT_W-1:0]   member_entries;
        logic [ENT_W-1:0]   member_expired;
        logic [CTR_W-1:0]   member_hits;
        logic [CTR_W-1:0]   member_misses;
        logic [CTR_W-1:0]   member_stores;
        logic [CTR_W-1:0]   member_removes;
    } in_item_t;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] member_count;
        logic [CNT_OUT_W-1:0] reporting_count;
        logic [SUM40_W-1:0]   copies_total;
        logic [SUM40_W-1:0]   fleet_entries;
        logic [SUM40_W-1:0]   fleet_expired;
        logic [SUM56_W-1:0]   hits_total;
        logic [SUM56_W-1:0]   misses_total;
        logic [SUM56_W-1:0]   stores_total;
        logic [SUM56_W-1:0]   removes_total;
    } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/fsa_stream_if.sv =====
`default_nettype none

interface fsa_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/fleet_stats_aggregator_unit.sv =====
// channel   | dir | payload               | beat
// ----------+-----+-----------------------+-------------------------------
// records   | in  | fsa_pkg::in_item_t    | one member record
// totals    | out | fsa_pkg::out_item_t   | fleet totals after a last record
// cfg_*     | in  | index 0 mode, 1 k     | register write, no handshake
//
// A non-reporting record needs only its accept; a reporting record adds eight
// passes through the shared 56-bit adder. A last record then passes the output
// state, in per-k mode after two 41-step restoring divides on the same adder.
// Reset clears counts, sums, maxima and the result valid flag; mode 0, k 1.
// A waiting result does not block new records; a finishing last record holds
// until the result register is free.
`default_nettype none

`include "fleet_stats_aggregator_unit_macros.svh"

module fleet_stats_aggregator_unit #(
    parameter int MAX_MEMBERS = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    fsa_stream_if.sink                  records,
    fsa_stream_if.source                totals,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [fsa_pkg::K_W-1:0]     cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_MEMBERS + 1);
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_MEMBERS);

    localparam logic CFG_BASIS_MODE = 1'b0;
    localparam logic CFG_COPIES_K   = 1'b1;

    localparam logic [1:0] MODE_SUM     = 2'd0;
    localparam logic [1:0] MODE_FULLEST = 2'd1;
    localparam logic [1:0] MODE_ATLEAST = 2'd2;
    localparam logic [1:0] MODE_PER_K   = 2'd3;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ESUM = 4'd1;
    localparam logic [3:0] S_EMAX = 4'd2;
    localparam logic [3:0] S_XSUM = 4'd3;
    localparam logic [3:0] S_XMAX = 4'd4;
    localparam logic [3:0] S_HITS = 4'd5;
    localparam logic [3:0] S_MISS = 4'd6;
    localparam logic [3:0] S_STOR = 4'd7;
    localparam logic [3:0] S_REMV = 4'd8;
    localparam logic [3:0] S_RNDE = 4'd9;
    localparam logic [3:0] S_DIVE = 4'd10;
    localparam logic [3:0] S_RNDX = 4'd11;
    localparam logic [3:0] S_DIVX = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    localparam int AW = fsa_pkg::ALU_W;
    localparam int QW = fsa_pkg::DIVIDEND_W;
    localparam int KW = fsa_pkg::K_W;

    logic [3:0]                   state_reg, state_next;
    logic [1:0]                   mode_reg, mode_next;
    logic [KW-1:0]                k_reg, k_next;

    logic [CNT_W-1:0]             members_reg, members_next;
    logic [CNT_W-1:0]             reporting_reg, reporting_next;
    logic [fsa_pkg::SUM40_W-1:0]  esum_reg, esum_next;
    logic [fsa_pkg::SUM40_W-1:0]  xsum_reg, xsum_next;
    logic [fsa_pkg::ENT_W-1:0]    emax_reg, emax_next;
    logic [fsa_pkg::ENT_W-1:0]    xmax_reg, xmax_next;
    logic [fsa_pkg::SUM56_W-1:0]  hsum_reg, hsum_next;
    logic [fsa_pkg::SUM56_W-1:0]  msum_reg, msum_next;
    logic [fsa_pkg::SUM56_W-1:0]  ssum_reg, ssum_next;
    logic [fsa_pkg::SUM56_W-1:0]  rsum_reg, rsum_next;

    logic                         out_valid_reg, out_valid_next;
    fsa_pkg::out_item_t           out_item_reg, out_item_next;

    fsa_pkg::in_item_t            rec_reg, rec_next;
    logic [QW-1:0]                div_q_reg, div_q_next;
    logic [KW-1:0]                div_r_reg, div_r_next;
    logic [KW-1:0]                div_d_reg, div_d_next;
    logic [fsa_pkg::DCNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [fsa_pkg::SUM40_W-1:0]  fe_div_reg, fe_div_next;

    fsa_pkg::alu_ctrl_t           alu_ctrl;
    logic [AW-1:0]                alu_a;
    logic [AW-1:0]                alu_b;
    logic [AW-1:0]                alu_res;
    logic                         alu_carry;

    logic                         accept;
    logic                         reporting_rec;
    logic [3:0]                   finish_state;
    logic [KW:0]                  trial;
    logic [CNT_W+KW-1:0]          rep_x;
    logic [CNT_W+KW-1:0]          k_x;
    logic [KW-1:0]                d_clamp;
    logic [KW-1:0]                div_d_calc;
    logic [CNT_W+fsa_pkg::CNT_OUT_W-1:0] mem_x;
    logic [CNT_W+fsa_pkg::CNT_OUT_W-1:0] rep_out_x;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v >= MAX_C) ? MAX_C : v + CNT_W'(1);
    endfunction

    fsa_alu u_alu (
        .ctrl   (alu_ctrl),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_res),
        .carry  (alu_carry)
    );

    assign records.ready  = (state_reg == S_IDLE);
    assign accept         = records.valid && records.ready;
    assign reporting_rec  = records.payload.first || records.payload.present;
    assign finish_state   = (mode_reg == MODE_PER_K) ? S_RNDE : S_OUT;

    assign totals.valid   = out_valid_reg;
    assign totals.payload = out_item_reg;

    assign trial      = {div_r_reg, div_q_reg[QW-1]};
    assign rep_x      = {{KW{1'b0}}, reporting_reg};
    assign k_x        = (CNT_W + KW)'(k_reg);
    assign d_clamp    = (rep_x < k_x) ? rep_x[KW-1:0] : k_reg;
    assign div_d_calc = (d_clamp == '0) ? KW'(1) : d_clamp;

    assign mem_x      = {{fsa_pkg::CNT_OUT_W{1'b0}}, members_reg};
    assign rep_out_x  = {{fsa_pkg::CNT_OUT_W{1'b0}}, reporting_reg};

    // shared adder operand select
    always_comb
    begin
        alu_ctrl = '{sub: 1'b0, sat: fsa_pkg::SAT_NONE};
        alu_a    = '0;
        alu_b    = '0;
        unique case (state_reg)
            S_ESUM:
            begin
                alu_a    = AW'(esum_reg);
                alu_b    = AW'(rec_reg.member_entries);
                alu_ctrl = '{sub: 1'b0, sat: fsa_pkg::SAT_40};
            end
            S_EMAX:
            begin
                alu_a    = AW'(emax_reg);
                alu_b    = AW'(rec_reg.member_entries);
                alu_ctrl = '{sub: 1'b1, sat: fsa_pkg::SAT_NONE};
            end
            S_XSUM:
            begin
                alu_a    = AW'(xsum_reg);
                alu_b    = AW'(rec_reg.member_expired);
                alu_ctrl = '{sub: 1'b0, sat: fsa_pkg::SAT_40};
            end
            S_XMAX:
            begin
                alu_a    = AW'(xmax_reg);
                alu_b    = AW'(rec_reg.member_expired);
                alu_ctrl = '{sub: 1'b1, sat: fsa_pkg::SAT_NONE};
            end
            S_HITS:
            begin
                alu_a    = hsum_reg;
                alu_b    = AW'(rec_reg.member_hits);
                alu_ctrl = '{sub: 1'b0, sat: fsa_pkg::SAT_56};
            end
            S_MISS:
            begin
                alu_a    = msum_reg;
                alu_b    = AW'(rec_reg.member_misses);
                alu_ctrl = '{sub: 1'b0, sat: fsa_pkg::SAT_56};
            end
            S_STOR:
            begin
                alu_a    = ssum_reg;
                alu_b    = AW'(rec_reg.member_stores);
                alu_ctrl = '{sub: 1'b0, sat: fsa_pkg::SAT_56};
            end
            S_REMV:
            begin
                alu_a    = rsum_reg;
                alu_b    = AW'(rec_reg.member_removes);
                alu_ctrl = '{sub: 1'b0, sat: fsa_pkg::SAT_56};
            end
            S_RNDE:
            begin
                alu_a = AW'(esum_reg);
                alu_b = AW'(div_d_calc >> 1);
            end
            S_RNDX:
            begin
                alu_a = AW'(xsum_reg);
                alu_b = AW'(div_d_reg >> 1);
            end
            S_DIVE, S_DIVX:
            begin
                alu_a    = AW'(trial);
                alu_b    = AW'(div_d_reg);
                alu_ctrl = '{sub: 1'b1, sat: fsa_pkg::SAT_NONE};
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        k_next         = k_reg;
        members_next   = members_reg;
        reporting_next = reporting_reg;
        esum_next      = esum_reg;
        xsum_next      = xsum_reg;
        emax_next      = emax_reg;
        xmax_next      = xmax_reg;
        hsum_next      = hsum_reg;
        msum_next      = msum_reg;
        ssum_next      = ssum_reg;
        rsum_next      = rsum_reg;
        out_valid_next = out_valid_reg && !totals.ready;
        out_item_next  = out_item_reg;
        rec_next       = rec_reg;
        div_q_next     = div_q_reg;
        div_r_next     = div_r_reg;
        div_d_next     = div_d_reg;
        div_cnt_next   = div_cnt_reg;
        fe_div_next    = fe_div_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BASIS_MODE: mode_next = cfg_wdata[fsa_pkg::MODE_W-1:0];
                CFG_COPIES_K:   k_next    = cfg_wdata;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rec_next = records.payload;
                    if (records.payload.first)
                    begin
                        members_next   = CNT_W'(1);
                        reporting_next = CNT_W'(1);
                        esum_next      = '0;
                        xsum_next      = '0;
                        emax_next      = '0;
                        xmax_next      = '0;
                        hsum_next      = '0;
                        msum_next      = '0;
                        ssum_next      = '0;
                        rsum_next      = '0;
                    end
                    else
                    begin
                        members_next = sat_inc(members_reg);
                        if (records.payload.present)
                        begin
                            reporting_next = sat_inc(reporting_reg);
                        end
                    end
                    priority if (reporting_rec)
                    begin
                        state_next = S_ESUM;
                    end
                    else if (records.payload.last)
                    begin
                        state_next = finish_state;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ESUM:
            begin
                esum_next  = alu_res[fsa_pkg::SUM40_W-1:0];
                state_next = S_EMAX;
            end
            S_EMAX:
            begin
                if (!alu_carry)
                begin
                    emax_next = rec_reg.member_entries;
                end
                state_next = S_XSUM;
            end
            S_XSUM:
            begin
                xsum_next  = alu_res[fsa_pkg::SUM40_W-1:0];
                state_next = S_XMAX;
            end
            S_XMAX:
            begin
                if (!alu_carry)
                begin
                    xmax_next = rec_reg.member_expired;
                end
                state_next = S_HITS;
            end
            S_HITS:
            begin
                hsum_next  = alu_res;
                state_next = S_MISS;
            end
            S_MISS:
            begin
                msum_next  = alu_res;
                state_next = S_STOR;
            end
            S_STOR:
            begin
                ssum_next  = alu_res;
                state_next = S_REMV;
            end
            S_REMV:
            begin
                rsum_next  = alu_res;
                state_next = rec_reg.last ? finish_state : S_IDLE;
            end
            S_RNDE, S_RNDX:
            begin
                div_q_next   = alu_res[QW-1:0];
                div_r_next   = '0;
                div_cnt_next = fsa_pkg::DCNT_W'(QW);
                if (state_reg == S_RNDE)
                begin
                    div_d_next = div_d_calc;
                end
                state_next = (state_reg == S_RNDE) ? S_DIVE : S_DIVX;
            end
            S_DIVE, S_DIVX:
            begin
                div_r_next   = alu_carry ? alu_res[KW-1:0] : trial[KW-1:0];
                div_q_next   = {div_q_reg[QW-2:0], alu_carry};
                div_cnt_next = div_cnt_reg - fsa_pkg::DCNT_W'(1);
                if (div_cnt_reg == fsa_pkg::DCNT_W'(1))
                begin
                    if (state_reg == S_DIVE)
                    begin
                        fe_div_next = div_q_next[fsa_pkg::SUM40_W-1:0];
                        state_next  = S_RNDX;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || totals.ready)
                begin
                    out_valid_next                = 1'b1;
                    out_item_next.member_count    = mem_x[fsa_pkg::CNT_OUT_W-1:0];
                    out_item_next.reporting_count = rep_out_x[fsa_pkg::CNT_OUT_W-1:0];
                    out_item_next.copies_total    = esum_reg;
                    out_item_next.hits_total      = hsum_reg;
                    out_item_next.misses_total    = msum_reg;
                    out_item_next.stores_total    = ssum_reg;
                    out_item_next.removes_total   = rsum_reg;
                    unique case (mode_reg)
                        MODE_SUM:
                        begin
                            out_item_next.fleet_entries = esum_reg;
                            out_item_next.fleet_expired = xsum_reg;
                        end
                        MODE_FULLEST, MODE_ATLEAST:
                        begin
                            out_item_next.fleet_entries = fsa_pkg::SUM40_W'(emax_reg);
                            out_item_next.fleet_expired = fsa_pkg::SUM40_W'(xmax_reg);
                        end
                        MODE_PER_K:
                        begin
                            out_item_next.fleet_entries = fe_div_reg;
                            out_item_next.fleet_expired = div_q_reg[fsa_pkg::SUM40_W-1:0];
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_SUM;
            k_reg         <= KW'(1);
            members_reg   <= '0;
            reporting_reg <= '0;
            esum_reg      <= '0;
            xsum_reg      <= '0;
            emax_reg      <= '0;
            xmax_reg      <= '0;
            hsum_reg      <= '0;
            msum_reg      <= '0;
            ssum_reg      <= '0;
            rsum_reg      <= '0;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            k_reg         <= k_next;
            members_reg   <= members_next;
            reporting_reg <= reporting_next;
            esum_reg      <= esum_next;
            xsum_reg      <= xsum_next;
            emax_reg      <= emax_next;
            xmax_reg      <= xmax_next;
            hsum_reg      <= hsum_next;
            msum_reg      <= msum_next;
            ssum_reg      <= ssum_next;
            rsum_reg      <= rsum_next;
            out_valid_reg <= out_valid_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg      <= rec_next;
        out_item_reg <= out_item_next;
        div_q_reg    <= div_q_next;
        div_r_reg    <= div_r_next;
        div_d_reg    <= div_d_next;
        fe_div_reg   <= fe_div_next;
    end

    `FSA_CHECK_NEXT(a_first_restarts, accept && records.payload.first, members_reg == CNT_W'(1), "first record did not restart member count")
    `FSA_CHECK(a_rep_le_members, 1'b1, reporting_reg <= members_reg, "reporting count above member count")
    `FSA_CHECK(a_members_bound, 1'b1, members_reg <= MAX_C, "member count above bound")
    `FSA_CHECK(a_div_remainder, (state_reg == S_DIVE) || (state_reg == S_DIVX), div_r_reg < div_d_reg, "divide remainder not below divisor")

endmodule

`default_nettype wire

// ===== hdl/fsa_alu.sv =====
`default_nettype none

module fsa_alu (
    input  fsa_pkg::alu_ctrl_t             ctrl,
    input  logic [fsa_pkg::ALU_W-1:0]      a,
    input  logic [fsa_pkg::ALU_W-1:0]      b,
    output logic [fsa_pkg::ALU_W-1:0]      result,
    output logic                           carry
);

    logic [fsa_pkg::ALU_W-1:0] b_eff;
    logic [fsa_pkg::ALU_W:0]   raw;

    assign b_eff = ctrl.sub ? ~b : b;
    assign raw   = {1'b0, a} + {1'b0, b_eff} + {{fsa_pkg::ALU_W{1'b0}}, ctrl.sub};
    assign carry = raw[fsa_pkg::ALU_W];

    // saturation: operands stay below the limit, so one spill bit flags overflow
    always_comb
    begin
        priority if (ctrl.sat == fsa_pkg::SAT_56 && raw[fsa_pkg::SUM56_W])
        begin
            result = {fsa_pkg::ALU_W{1'b1}};
        end
        else if (ctrl.sat == fsa_pkg::SAT_40 && raw[fsa_pkg::SUM40_W])
        begin
            result = {{(fsa_pkg::ALU_W - fsa_pkg::SUM40_W){1'b0}},
                      {fsa_pkg::SUM40_W{1'b1}}};
        end
        else
        begin
            result = raw[fsa_pkg::ALU_W-1:0];
        end
    end

endmodule

`default_nettype wire
